// ----- rtl/bads_pkg.sv -----
// ----------------------------------------------------------------------------
// bads_pkg: shared types and constants of the Bayer-aware downsampler
// Register indexes, field widths, reset values and the pending-pair record.
// ----------------------------------------------------------------------------
package bads_pkg;

  // field widths
  localparam int PixW = 8;
  localparam int SumW = 9;
  localparam int CfgW = 13;
  localparam int PowW = 4;
  localparam int IdxW = 2;

  // register indexes
  localparam logic [IdxW-1:0] RegFrameRows  = 2'd0;
  localparam logic [IdxW-1:0] RegFrameCols  = 2'd1;
  localparam logic [IdxW-1:0] RegShrinkPow  = 2'd2;

  // reset values and limits
  localparam int RowsRst = 480;
  localparam int ColsRst = 640;
  localparam int DimMin  = 4;
  localparam int PowRst  = 1;
  localparam int PowMin  = 1;
  localparam int PowMax  = 10;

  // one pair waiting for its stored sums to come out of memory
  typedef struct packed {
    logic            hi;    // second chunk row pair (Gr,R)
    logic            last;  // closes the frame
    logic [SumW-1:0] ev;
    logic [SumW-1:0] od;
  } pend_t;

endpackage

// ----- rtl/bayer_aware_downsampler_top.sv -----
// ----------------------------------------------------------------------------
// bayer_aware_downsampler_top: raw Bayer binning downsampler
// Averages the top-left 4x4 of each chunk into one 2x2 Bayer quad.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one 8-bit raw sample per item
//   in raster order, frame after frame. Output channel (out_valid_o/
//   out_ready_i) gives two items per finished half-quad: B,Gb on chunk row 2
//   col 3, Gr,R on chunk row 3 col 3; last_of_pair_o marks the second,
//   frame_done_o the R sample of the frame's last full chunk.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; any write to a
//   known index restarts the frame. Write only while idle.
//   Throughput: one input item per cycle while in_ready_o is high. Path: the
//   RAM read happens at the edge that accepts the triggering sample, and the
//   pending stage loads there too; the output pair register loads from it
//   once it is empty or handing over its last item.
//   The accumulator RAMs see at most one access per sample.
//   Stall: a stalled receiver holds the output pair; non-producing samples
//   keep flowing, a producing one waits only while the pending stage is full
//   and the output pair register cannot take its pair.
//   Reset: position and row sums clear, registers take 480/640/1. The
//   accumulator RAMs are not cleared: every read follows a write.
// ----------------------------------------------------------------------------
module bayer_aware_downsampler_top #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bads_pkg::IdxW-1:0]   cfg_index_i,
  input  logic [bads_pkg::CfgW-1:0]   cfg_data_i,
  // input samples
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bads_pkg::PixW-1:0]   raw_pixel_i,
  // output samples
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bads_pkg::PixW-1:0]   out_pixel_o,
  output logic                        last_of_pair_o,
  output logic                        frame_done_o
);

  localparam int PosCW   = $clog2(MAX_COLS);
  localparam int PosRW   = $clog2(MAX_ROWS);
  localparam int DimCW   = $clog2(MAX_COLS + 1);
  localparam int DimRW   = $clog2(MAX_ROWS + 1);
  localparam int Entries = MAX_COLS / 4;
  localparam int SlotW   = $clog2(Entries);
  localparam int MaxPosW = (PosCW > PosRW) ? PosCW : PosRW;
  localparam int CmpW    = ((MaxPosW > 12) ? MaxPosW : 12) + 2;
  localparam int HalfW   = 2 * bads_pkg::SumW;
  localparam int SW      = bads_pkg::SumW;
  localparam int RowsRstC = (bads_pkg::RowsRst > MAX_ROWS) ? MAX_ROWS : bads_pkg::RowsRst;
  localparam int ColsRstC = (bads_pkg::ColsRst > MAX_COLS) ? MAX_COLS : bads_pkg::ColsRst;

  // --------------------------------------------------------------------------
  // configuration, stored already clamped
  // --------------------------------------------------------------------------
  logic [DimRW-1:0]          rows_q;
  logic [DimCW-1:0]          cols_q;
  logic [bads_pkg::PowW-1:0] pw_q;
  logic [31:0]               cfg_ext;
  logic [bads_pkg::PowW-1:0] pw_raw;
  logic [DimRW-1:0]          rows_cl;
  logic [DimCW-1:0]          cols_cl;
  logic [bads_pkg::PowW-1:0] pw_cl;
  logic                      cfg_we;
  logic                      restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_ext     = 32'(cfg_data_i);
  // shrink power register keeps only its low 4 bits
  assign pw_raw      = cfg_data_i[bads_pkg::PowW-1:0];

  always_comb begin
    if (cfg_ext < 32'(bads_pkg::DimMin)) begin
      rows_cl = DimRW'(bads_pkg::DimMin);
    end else if (cfg_ext > 32'(MAX_ROWS)) begin
      rows_cl = DimRW'(MAX_ROWS);
    end else begin
      rows_cl = DimRW'(cfg_ext);
    end
    if (cfg_ext < 32'(bads_pkg::DimMin)) begin
      cols_cl = DimCW'(bads_pkg::DimMin);
    end else if (cfg_ext > 32'(MAX_COLS)) begin
      cols_cl = DimCW'(MAX_COLS);
    end else begin
      cols_cl = DimCW'(cfg_ext);
    end
    if (pw_raw < bads_pkg::PowW'(bads_pkg::PowMin)) begin
      pw_cl = bads_pkg::PowW'(bads_pkg::PowMin);
    end else if (pw_raw > bads_pkg::PowW'(bads_pkg::PowMax)) begin
      pw_cl = bads_pkg::PowW'(bads_pkg::PowMax);
    end else begin
      pw_cl = pw_raw;
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        bads_pkg::RegFrameRows: restart = 1'b1;
        bads_pkg::RegFrameCols: restart = 1'b1;
        bads_pkg::RegShrinkPow: restart = 1'b1;
        default:                restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimRW'(RowsRstC);
      cols_q <= DimCW'(ColsRstC);
      pw_q   <= bads_pkg::PowW'(bads_pkg::PowRst);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        bads_pkg::RegFrameRows: rows_q <= rows_cl;
        bads_pkg::RegFrameCols: cols_q <= cols_cl;
        bads_pkg::RegShrinkPow: pw_q   <= pw_cl;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // position decode
  // --------------------------------------------------------------------------
  logic [PosRW-1:0]  row_q, row_d;
  logic [PosCW-1:0]  col_q, col_d;
  logic [SW-1:0]     ev_q, ev_d, od_q, od_d;
  logic [CmpW-1:0]   side, mask_c;
  logic [PosRW-1:0]  lr_full, rstart;
  logic [PosCW-1:0]  lc_full, cstart;
  logic [PosCW-1:0]  slot_raw, slot_w;
  logic [SlotW-1:0]  slot;
  logic              in44, full_chunk, is_last, prod_pos;
  logic [1:0]        lr, lc;
  logic [PosCW:0]    col_inc;
  logic [PosRW:0]    row_inc;
  logic              in_acc;

  assign side    = CmpW'(2) << pw_q;
  assign mask_c  = side - CmpW'(1);
  assign lr_full = row_q & mask_c[PosRW-1:0];
  assign lc_full = col_q & mask_c[PosCW-1:0];
  assign rstart  = row_q & ~mask_c[PosRW-1:0];
  assign cstart  = col_q & ~mask_c[PosCW-1:0];
  assign lr      = lr_full[1:0];
  assign lc      = lc_full[1:0];
  assign in44    = (lr_full[PosRW-1:2] == '0) && (lc_full[PosCW-1:2] == '0);

  // chunk column slot; only the very last chunk of a max width that is not a multiple of four wraps
  assign slot_raw = col_q >> (pw_q + bads_pkg::PowW'(1));
  assign slot_w   = (slot_raw >= PosCW'(Entries)) ? slot_raw - PosCW'(Entries) : slot_raw;
  assign slot     = slot_w[SlotW-1:0];

  assign full_chunk = (CmpW'(cstart) + side <= CmpW'(cols_q)) &&
                      (CmpW'(rstart) + side <= CmpW'(rows_q));
  assign is_last    = (lr == 2'd3) &&
                      (CmpW'(cstart) + (side << 1) > CmpW'(cols_q)) &&
                      (CmpW'(rstart) + (side << 1) > CmpW'(rows_q));
  assign prod_pos   = in44 && (lc == 2'd3) && lr[1] && full_chunk;

  // row sums inside the chunk: even columns and odd columns
  always_comb begin
    ev_d = ev_q;
    od_d = od_q;
    unique case (lc)
      2'd0: ev_d = SW'(raw_pixel_i);
      2'd1: od_d = SW'(raw_pixel_i);
      2'd2: ev_d = ev_q + SW'(raw_pixel_i);
      2'd3: od_d = od_q + SW'(raw_pixel_i);
      default: ;
    endcase
  end

  assign col_inc = {1'b0, col_q} + (PosCW + 1)'(1);
  assign row_inc = {1'b0, row_q} + (PosRW + 1)'(1);

  always_comb begin
    col_d = col_inc[PosCW-1:0];
    row_d = row_q;
    if (col_inc >= (PosCW + 1)'(cols_q)) begin
      col_d = '0;
      row_d = (row_inc >= (PosRW + 1)'(rows_q)) ? '0 : row_inc[PosRW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ev_q  <= '0;
      od_q  <= '0;
    end else if (restart) begin
      row_q <= '0;
      col_q <= '0;
      ev_q  <= '0;
      od_q  <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
      if (in44) begin
        ev_q <= ev_d;
        od_q <= od_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // accumulator RAMs: A holds chunk row 0 sums, B chunk row 1 sums.
  // A is written on row 0 and read on row 2, B written on row 1 and read on
  // row 3, so a port never sees a read and a write of the same cycle, and a
  // read always lands at least one item after the write it needs.
  // --------------------------------------------------------------------------
  logic [HalfW-1:0] mem_a [Entries];
  logic [HalfW-1:0] mem_b [Entries];
  logic [HalfW-1:0] rda_q, rdb_q;
  logic             wr_a, wr_b, rd_a, rd_b;
  logic [HalfW-1:0] wdata;

  assign wdata = {od_d, ev_d};
  assign wr_a  = in_acc && in44 && (lc == 2'd3) && (lr == 2'd0);
  assign wr_b  = in_acc && in44 && (lc == 2'd3) && (lr == 2'd1);
  assign rd_a  = in_acc && prod_pos && (lr == 2'd2);
  assign rd_b  = in_acc && prod_pos && (lr == 2'd3);

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[slot] <= wdata;
    end
    if (rd_a) begin
      rda_q <= mem_a[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[slot] <= wdata;
    end
    if (rd_b) begin
      rdb_q <= mem_b[slot];
    end
  end

  // --------------------------------------------------------------------------
  // pending stage (waits for RAM data) and output pair register
  // --------------------------------------------------------------------------
  logic                      p_valid_q;
  bads_pkg::pend_t           p_q;
  logic                      p_move;
  logic [1:0]                ob_cnt_q;
  logic [bads_pkg::PixW-1:0] ob_pix0_q, ob_pix1_q;
  logic                      ob_last_q;
  logic [HalfW-1:0]          rd_sel;
  logic [SW:0]               sum0, sum1;
  logic                      out_acc;

  assign p_move     = p_valid_q && ((ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_ready_i));
  assign in_ready_o = !(prod_pos && p_valid_q && !p_move);
  assign in_acc     = in_valid_i && in_ready_o && !restart;
  assign out_acc    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (rd_a || rd_b) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_a || rd_b) begin
      p_q.hi   <= (lr == 2'd3);
      p_q.last <= is_last;
      p_q.ev   <= ev_d;
      p_q.od   <= od_d;
    end
  end

  assign rd_sel = p_q.hi ? rdb_q : rda_q;
  assign sum0   = {1'b0, rd_sel[SW-1:0]}     + {1'b0, p_q.ev};
  assign sum1   = {1'b0, rd_sel[HalfW-1:SW]} + {1'b0, p_q.od};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else if (p_move) begin
      ob_cnt_q <= 2'd2;
    end else if (out_acc) begin
      ob_cnt_q <= ob_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      ob_pix0_q <= sum0[SW:2];
      ob_pix1_q <= sum1[SW:2];
      ob_last_q <= p_q.last;
    end
  end

  assign out_valid_o    = (ob_cnt_q != 2'd0);
  assign out_pixel_o    = (ob_cnt_q == 2'd2) ? ob_pix0_q : ob_pix1_q;
  assign last_of_pair_o = (ob_cnt_q == 2'd1);
  assign frame_done_o   = (ob_cnt_q == 2'd1) && ob_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_ram_a_no_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_a && rd_a) && !(wr_b && rd_b))
    else $error("accumulator RAM read and write in the same cycle");

  a_read_feeds_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_a || rd_b) |=> p_valid_q)
    else $error("RAM read without pending stage");

  a_pend_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !p_move) |=> (p_valid_q && $stable(p_q)))
    else $error("stalled pending pair lost");

  a_move_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_move |=> (ob_cnt_q == 2'd2))
    else $error("output pair register not loaded");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_cnt_q == 2'd2) && !out_ready_i |=> (ob_cnt_q == 2'd2))
    else $error("output pair drained without handshake");

endmodule

// ----- verif/bads_checker.sv -----
// ----------------------------------------------------------------------------
// bads_checker: result predictor and scoreboard for the Bayer downsampler
// Watches the config, sample and result channels, bins accepted samples
// into expected quad samples and compares each result against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bads_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [bads_pkg::IdxW-1:0]   cfg_index_i,
  input  logic [bads_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [bads_pkg::PixW-1:0]   raw_pixel_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bads_pkg::PixW-1:0]   out_pixel_i,
  input  logic                        last_of_pair_i,
  input  logic                        frame_done_i,
  output int                          err_cnt_o,
  output int                          pend_cnt_o
);

  localparam int MaxDim = 4096;
  localparam int Slots  = MaxDim / 4;

  typedef struct packed {
    logic [bads_pkg::PixW-1:0] pixel;
    logic                      pair_end;
    logic                      frame_end;
  } quad_sample_t;

  quad_sample_t                quad_q[$];
  logic [bads_pkg::CfgW-1:0]   rows_reg = bads_pkg::CfgW'(bads_pkg::RowsRst);
  logic [bads_pkg::CfgW-1:0]   cols_reg = bads_pkg::CfgW'(bads_pkg::ColsRst);
  logic [bads_pkg::PowW-1:0]   pow_reg  = bads_pkg::PowW'(bads_pkg::PowRst);
  int                          row_pos, col_pos;
  logic [bads_pkg::SumW-1:0]   run_ev, run_od;
  // chunk rows 0 and 1 per chunk column: {R, Gr, Gb, B}
  logic [4*bads_pkg::SumW-1:0] strip_sums [Slots];
  int                          errors = 0;

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic restart_frame();
    row_pos = 0;
    col_pos = 0;
    run_ev  = '0;
    run_od  = '0;
  endtask

  task automatic bin_sample(input logic [bads_pkg::PixW-1:0] pix);
    int                        rows, cols, pw, side, lr, lc, rstart, cstart, slot;
    logic [bads_pkg::SumW-1:0] pe, po;
    quad_sample_t              s;
    rows   = clamp(rows_reg, bads_pkg::DimMin, MaxDim);
    cols   = clamp(cols_reg, bads_pkg::DimMin, MaxDim);
    pw     = clamp(pow_reg, bads_pkg::PowMin, bads_pkg::PowMax);
    side   = 2 << pw;
    lr     = row_pos & (side - 1);
    lc     = col_pos & (side - 1);
    rstart = row_pos - lr;
    cstart = col_pos - lc;
    slot   = (col_pos >> (pw + 1)) % Slots;
    if (lr < 4 && lc < 4) begin
      case (lc)
        0: run_ev = pix;
        1: run_od = pix;
        2: run_ev = run_ev + pix;
        default: run_od = run_od + pix;
      endcase
      if (lc == 3) begin
        if (lr == 0) begin
          strip_sums[slot][2*bads_pkg::SumW-1:0] = {run_od, run_ev};
        end else if (lr == 1) begin
          strip_sums[slot][4*bads_pkg::SumW-1:2*bads_pkg::SumW] = {run_od, run_ev};
        end else if (cstart + side <= cols && rstart + side <= rows) begin
          if (lr == 2) {po, pe} = strip_sums[slot][2*bads_pkg::SumW-1:0];
          else         {po, pe} = strip_sums[slot][4*bads_pkg::SumW-1:2*bads_pkg::SumW];
          s.pixel     = bads_pkg::PixW'((int'(pe) + int'(run_ev)) >> 2);
          s.pair_end  = 1'b0;
          s.frame_end = 1'b0;
          quad_q.push_back(s);
          s.pixel     = bads_pkg::PixW'((int'(po) + int'(run_od)) >> 2);
          s.pair_end  = 1'b1;
          s.frame_end = (lr == 3) && (cstart + 2 * side > cols) &&
                        (rstart + 2 * side > rows);
          quad_q.push_back(s);
        end
      end
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  task automatic check_result();
    quad_sample_t want;
    if (quad_q.size() == 0) begin
      $error("unexpected result: out_pixel %0d last_of_pair %0d frame_done %0d",
             out_pixel_i, last_of_pair_i, frame_done_i);
      errors++;
    end else begin
      want = quad_q.pop_front();
      if (out_pixel_i !== want.pixel) begin
        $error("out_pixel: expected %0d, got %0d", want.pixel, out_pixel_i);
        errors++;
      end
      if (last_of_pair_i !== want.pair_end) begin
        $error("last_of_pair: expected %0d, got %0d", want.pair_end, last_of_pair_i);
        errors++;
      end
      if (frame_done_i !== want.frame_end) begin
        $error("frame_done: expected %0d, got %0d", want.frame_end, frame_done_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rows_reg = bads_pkg::CfgW'(bads_pkg::RowsRst);
      cols_reg = bads_pkg::CfgW'(bads_pkg::ColsRst);
      pow_reg  = bads_pkg::PowW'(bads_pkg::PowRst);
      restart_frame();
      quad_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bads_pkg::RegFrameRows: begin
            rows_reg = cfg_data_i;
            restart_frame();
          end
          bads_pkg::RegFrameCols: begin
            cols_reg = cfg_data_i;
            restart_frame();
          end
          bads_pkg::RegShrinkPow: begin
            pow_reg = cfg_data_i[bads_pkg::PowW-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) bin_sample(raw_pixel_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    err_cnt_o  = errors;
    pend_cnt_o = quad_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the Bayer-aware binning downsampler
// Drives raw frames under several geometries and shrink powers, with random
// idling on both channels; a checker beside the block predicts every quad
// sample and scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  // index past the register list: must be ignored, no frame restart
  localparam logic [bads_pkg::IdxW-1:0] RegSpare = 2'd3;
  // idle cycles before a config write: covers the pending stage and output pair with margin
  localparam int DrainWait   = 8;
  localparam int CycleLimit  = 1_000_000;
  localparam int RandomItems = 230;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [bads_pkg::IdxW-1:0]   cfg_index_i = '0;
  logic [bads_pkg::CfgW-1:0]   cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [bads_pkg::PixW-1:0]   raw_pixel_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [bads_pkg::PixW-1:0]   out_pixel_o;
  logic                        last_of_pair_o;
  logic                        frame_done_o;

  int                err_cnt;
  int                pend_cnt;
  int                cycles = 0;
  // when set, neither side idles (long clean stretch)
  bit                steady = 1'b0;

  bayer_aware_downsampler_top dut (.*);

  bads_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .raw_pixel_i    (raw_pixel_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_i    (out_pixel_o),
    .last_of_pair_i (last_of_pair_o),
    .frame_done_i   (frame_done_o),
    .err_cnt_o      (err_cnt),
    .pend_cnt_o     (pend_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bayer_aware_downsampler_top test failed");
      $finish;
    end
  end

  // receiver: stalls about 15% of cycles unless in a steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 15);
  end

  // pixel mix: extremes often, otherwise uniform
  function automatic logic [bads_pkg::PixW-1:0] pick_pixel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return bads_pkg::PixW'($urandom_range(0, 255));
  endfunction

  // One sample item. Called at a falling edge, returns at a falling edge.
  // hold: wait until every expected result has drained before sending.
  task automatic push_pixel(input logic [bads_pkg::PixW-1:0] pix, input bit hold);
    if (hold) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (pend_cnt != 0);
    end
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_pixel_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic stream(input int n);
    for (int i = 0; i < n; i++) push_pixel(pick_pixel(), $urandom_range(0, 299) == 0);
  endtask

  // block idle: no sample offered, scoreboard empty, pipeline flushed
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after its last write
  task automatic write_reg(input logic [bads_pkg::IdxW-1:0] idx,
                           input logic [bads_pkg::CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [bads_pkg::CfgW-1:0] rows,
                           input logic [bads_pkg::CfgW-1:0] cols,
                           input logic [bads_pkg::PowW-1:0] pw);
    settle();
    write_reg(bads_pkg::RegFrameRows, rows);
    write_reg(bads_pkg::RegFrameCols, cols);
    write_reg(bads_pkg::RegShrinkPow, bads_pkg::CfgW'(pw));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int sel, pw, side, hi, rows, cols, wr_pw, eff_rows, frame, n;
    int rand_items;
    rand_items = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all-low register values saturate to a 4x4 frame, side 4.
    // Rows 0-2 at full scale, row 3 at zero: B,Gb = 255, Gr,R = 127, frame
    // done on R. The first row-3 sample waits for the B,Gb pair to drain.
    set_frame('0, bads_pkg::CfgW'(3), '0);
    for (int i = 0; i < 16; i++) push_pixel((i < 12) ? '1 : '0, i == 12);
    // start the next frame, then poke the spare index: the frame must go on
    for (int i = 0; i < 3; i++) push_pixel('0, 1'b0);
    settle();
    write_reg(RegSpare, '1);
    cfg_valid_i <= 1'b0;
    push_pixel('1, 1'b0);
    push_pixel('0, 1'b0);

    // Over-range values saturate to a 4096x4096 frame with the largest
    // chunk: samples only advance the position inside the first chunk.
    set_frame('1, bads_pkg::CfgW'(4096), '1);
    stream(24);

    // Wide strip of the smallest chunk, no idling on either side: two
    // frames back to back, four quads each.
    steady = 1'b1;
    set_frame(bads_pkg::CfgW'(4), bads_pkg::CfgW'(16), bads_pkg::PowW'(1));
    stream(2 * 4 * 16);
    steady = 1'b0;

    // Tall narrow frame: frame done on the bottom chunk, then wrap.
    set_frame(bads_pkg::CfgW'(12), bads_pkg::CfgW'(4), bads_pkg::PowW'(1));
    stream(12 * 4 + 4);

    // Random geometries: mostly small chunks, partial chunks at the edges,
    // now and then low out-of-range values and mid-frame restarts.
    while (rand_items < RandomItems) begin
      sel = $urandom_range(0, 9);
      pw = (sel < 6) ? 1 : (sel < 9) ? 2 : 3;
      side = 2 << pw;
      hi = (pw == 3) ? 2 * side + 2 : 3 * side + 3;
      rows = $urandom_range(4, hi);
      cols = $urandom_range(4, hi);
      wr_pw = pw;
      sel = $urandom_range(0, 7);
      if (sel == 0) rows = $urandom_range(0, 3);
      if (sel == 1 && pw == 1) wr_pw = 0;
      eff_rows = (rows < 4) ? 4 : rows;
      frame = eff_rows * cols;
      n = ($urandom_range(0, 3) != 0) ? frame * $urandom_range(1, 2)
                                      : $urandom_range(1, frame);
      if (n > RandomItems - rand_items) n = RandomItems - rand_items;
      set_frame(bads_pkg::CfgW'(rows), bads_pkg::CfgW'(cols), bads_pkg::PowW'(wr_pw));
      stream(n);
      rand_items += n;
    end

    settle();
    if (err_cnt == 0) begin
      $display("bayer_aware_downsampler_top test passed");
    end else begin
      $display("bayer_aware_downsampler_top test failed");
    end
    $finish;
  end

endmodule
